// ===== rtl/bfa_pkg.sv =====
// Package for the bitmap frame allocator: types, constants, opcodes, states.
// No dependencies.
package bfa_pkg;

	localparam int FRAMES_DEF      = 32768;
	localparam int FRAME_BYTES_DEF = 4096;
	localparam logic [15:0] COUNT_MAX = 16'hffff;

	typedef enum logic [2:0] {
		OP_RELEASE  = 3'd0,
		OP_RESERVE  = 3'd1,
		OP_MARK     = 3'd2,
		OP_ALLOC    = 3'd3,
		OP_FREE     = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOMEM     = 2'd1,
		ST_MISALIGN  = 2'd2,
		ST_ZERO      = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] address;
		logic [31:0] length;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] result_address;
		logic [15:0] used_frames;
		logic [15:0] free_frames;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_DECODE,
		S_FILL_RD,
		S_FILL_WR,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_MARK_RD,
		S_MARK_WR,
		S_FRAME0_RD,
		S_FRAME0_WR,
		S_DONE
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;        // capture request
		logic clr_step;    // write all-ones to clear pointer word
		logic decode;      // compute operation parameters
		logic rd_cur;      // read word at cursor frame
		logic fill_wr;     // write filled word, advance cursor
		logic scan_step;   // examine one frame of scan word
		logic mark_wr;     // set bit at start frame
		logic f0_rd;       // read word 0
		logic f0_wr;       // set frame 0
		logic finish;      // commit counters, emit result
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clr_done;
		logic op_fill;     // operation is a region/free fill
		logic op_scan;     // allocation needs a scan
		logic op_mark;     // mark with in-range frame
		logic op_release;
		logic fill_last;   // cursor reaches end of range after this word
		logic fill_empty;  // nothing to fill
		logic scan_found;
		logic scan_end;    // scan exhausted limit
		logic scan_word_end;
		logic scan_alloc;  // found run needs writing (restart as fill)
	} sts_t;

endpackage

// ===== rtl/bfa_datapath.sv =====
// Datapath of the frame allocator: bitmap memory, cursor, counters, result.
// Depends on bfa_pkg.
module bfa_datapath #(
	parameter int FRAMES      = bfa_pkg::FRAMES_DEF,
	parameter int FRAME_BYTES = bfa_pkg::FRAME_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  bfa_pkg::req_t req,
	input  logic          cfg_we,
	input  logic [15:0]   cfg_data,
	input  bfa_pkg::cmd_t cmd,
	output bfa_pkg::sts_t sts,
	output bfa_pkg::rsp_t rsp
);
	import bfa_pkg::*;

	localparam int WORDS = (FRAMES + 31) / 32;
	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int FB    = $clog2(FRAME_BYTES);
	localparam int FW    = 34;   // frame numbers incl. overflow of start+len

	logic [31:0] mem [WORDS];
	logic [31:0] rd_q;
	logic [AW-1:0] rd_addr;
	logic        wr_en;
	logic [AW-1:0] wr_addr;
	logic [31:0] wr_data;

	req_t        req_q;
	logic [15:0] total_q;
	logic [15:0] used_q;
	logic [AW:0] clr_q;
	logic [FW-1:0] cur_q;     // fill cursor / scan frame
	logic [FW-1:0] end_q;     // fill end (exclusive, clamped)
	logic [FW-1:0] limit_q;
	logic [FW-1:0] run_q;
	logic [FW-1:0] first_q;
	logic        fill_val_q;
	logic [32:0] cnt_delta_q;
	logic        cnt_add_q;
	logic        cnt_en_q;
	logic [1:0]  status_q;
	logic [31:0] res_q;
	logic        alloc_q;
	logic        op_fill_q, op_scan_q, op_mark_q, op_rel_q;

	// Operation decode
	logic [2:0]  kind_w;
	logic [FW-1:0] start_w, nfr_w, endraw_w, endc_w, endc2_w;
	logic [32:0] lenfr_w;
	logic [16:0] free_w;
	assign kind_w  = req_q.kind;
	assign start_w = FW'(req_q.address >> FB);
	assign lenfr_w = (33'(req_q.length) + 33'(FRAME_BYTES - 1)) >> FB;
	assign nfr_w   = FW'(lenfr_w);
	assign free_w  = (total_q > used_q) ? 17'(total_q - used_q) : 17'd0;

	// Fill word mask for the cursor word
	logic [FW-1:0] wbase_w, wnext_w;
	logic [31:0] mask_w;
	logic [5:0]  lo_w, hi_w;
	assign wbase_w = {cur_q[FW-1:5], 5'd0};
	assign wnext_w = wbase_w + FW'(32);
	assign lo_w = {1'b0, cur_q[4:0]};
	assign hi_w = (end_q >= wnext_w) ? 6'd32 : 6'(end_q - wbase_w);
	always_comb begin
		for (int i = 0; i < 32; i++)
			mask_w[i] = (6'(i) >= lo_w) && (6'(i) < hi_w);
	end

	// Memory port control
	always_comb begin
		rd_addr = AW'(cur_q >> 5);
		if (cmd.f0_rd)
			rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = AW'(cur_q >> 5);
		wr_data = rd_q;
		if (cmd.clr_step) begin
			wr_en = 1'b1;
			wr_addr = clr_q[AW-1:0];
			wr_data = '1;
		end else if (cmd.fill_wr) begin
			wr_en = 1'b1;
			wr_data = fill_val_q ? (rd_q | mask_w) : (rd_q & ~mask_w);
		end else if (cmd.mark_wr) begin
			wr_en = 1'b1;
			wr_data = rd_q | (32'd1 << cur_q[4:0]);
		end else if (cmd.f0_wr) begin
			wr_en = 1'b1;
			wr_addr = '0;
			wr_data = rd_q | 32'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	// Scan of one frame per cycle, pausing to read each new word
	logic        bit_w;
	logic [FW-1:0] run_n;
	assign bit_w = rd_q[cur_q[4:0]];
	assign run_n = bit_w ? '0 : run_q + FW'(1);

	// Counter update
	logic [33:0] add_w;
	logic [15:0] used_n;
	assign add_w = 34'(used_q) + 34'(cnt_delta_q);
	always_comb begin
		used_n = used_q;
		if (cnt_en_q) begin
			if (cnt_add_q)
				used_n = (add_w > 34'(COUNT_MAX)) ? COUNT_MAX : add_w[15:0];
			else
				used_n = (cnt_delta_q >= 33'(used_q)) ? 16'd0 :
					16'(33'(used_q) - cnt_delta_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			total_q <= '0;
			used_q  <= '0;
		end else begin
			if (cmd.clr_step)
				clr_q <= clr_q + 1'b1;
			if (cfg_we) begin
				total_q <= cfg_data;
				used_q  <= cfg_data;
			end else if (cmd.finish) begin
				used_q <= used_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			req_q <= req;
		if (cmd.decode) begin
			status_q    <= ST_OK;
			res_q       <= '0;
			cnt_en_q    <= 1'b0;
			cnt_add_q   <= 1'b0;
			cnt_delta_q <= '0;
			op_fill_q   <= 1'b0;
			op_scan_q   <= 1'b0;
			op_mark_q   <= 1'b0;
			op_rel_q    <= 1'b0;
			alloc_q     <= 1'b0;
			run_q       <= '0;
			limit_q     <= (total_q > 16'(FRAMES > 65535 ? 65535 : FRAMES)) ?
				FW'(FRAMES) : FW'(total_q);
			cur_q       <= start_w;
			case (kind_w)
				OP_RELEASE: begin
					end_q <= endc_w;
					fill_val_q <= 1'b0;
					op_fill_q <= 1'b1;
					op_rel_q <= 1'b1;
					cnt_en_q <= 1'b1;
					cnt_delta_q <= lenfr_w;
				end
				OP_RESERVE: begin
					end_q <= endc_w;
					fill_val_q <= 1'b1;
					op_fill_q <= 1'b1;
					cnt_en_q <= 1'b1;
					cnt_add_q <= 1'b1;
					cnt_delta_q <= lenfr_w;
				end
				OP_MARK: begin
					op_mark_q <= (start_w < FW'(FRAMES));
				end
				OP_ALLOC: begin
					cur_q <= '0;
					if (req_q.length == 32'd0)
						status_q <= ST_ZERO;
					else if (33'(free_w) < 33'(req_q.length))
						status_q <= ST_NOMEM;
					else
						op_scan_q <= 1'b1;
				end
				OP_FREE: begin
					if (req_q.address[FB-1:0] != '0) begin
						status_q <= ST_MISALIGN;
					end else begin
						end_q <= endc2_w;
						fill_val_q <= 1'b0;
						op_fill_q <= 1'b1;
						cnt_en_q <= 1'b1;
						cnt_delta_q <= 33'(req_q.length);
					end
				end
				default: ;
			endcase
		end else if (cmd.fill_wr) begin
			cur_q <= wnext_w;
		end else if (cmd.mark_wr) begin
			// count only a frame that was free
			cnt_en_q <= !bit_w;
			cnt_add_q <= 1'b1;
			cnt_delta_q <= 33'd1;
		end else if (cmd.scan_step) begin
			run_q <= run_n;
			if (run_n == FW'(req_q.length)) begin
				first_q <= cur_q + FW'(1) - FW'(req_q.length);
				alloc_q <= 1'b1;
			end else if (cur_q + FW'(1) >= limit_q) begin
				status_q <= ST_NOMEM;
			end
			cur_q <= cur_q + FW'(1);
		end else if (cmd.rd_cur && alloc_q && op_scan_q) begin
			// switch found run over to a set fill
			op_scan_q   <= 1'b0;
			op_fill_q   <= 1'b1;
			fill_val_q  <= 1'b1;
			cur_q       <= first_q;
			end_q       <= first_q + FW'(req_q.length);
			cnt_en_q    <= 1'b1;
			cnt_add_q   <= 1'b1;
			cnt_delta_q <= 33'(req_q.length);
			res_q       <= 32'(first_q << FB);
		end
	end

	assign endraw_w = start_w + nfr_w;
	assign endc_w   = (endraw_w > FW'(FRAMES)) ? FW'(FRAMES) : endraw_w;
	assign endc2_w  = ((start_w + FW'(req_q.length)) > FW'(FRAMES)) ? FW'(FRAMES) :
		start_w + FW'(req_q.length);

	// Status to controller
	always_comb begin
		sts.clr_done      = (clr_q == (AW+1)'(WORDS - 1));
		sts.op_fill       = op_fill_q;
		sts.op_scan       = op_scan_q;
		sts.op_mark       = op_mark_q;
		sts.op_release    = op_rel_q;
		sts.fill_last     = (wnext_w >= end_q);
		sts.fill_empty    = (cur_q >= end_q);
		sts.scan_found    = (run_n == FW'(req_q.length));
		sts.scan_end      = (cur_q + FW'(1) >= limit_q);
		sts.scan_word_end = (cur_q[4:0] == 5'd31);
		sts.scan_alloc    = alloc_q;
	end

	// Result
	always_comb begin
		rsp.status         = alloc_q ? ST_OK : status_q;
		rsp.result_address = res_q;
		rsp.used_frames    = used_n;
		rsp.free_frames    = (total_q > used_n) ? total_q - used_n : 16'd0;
	end

endmodule

// ===== rtl/bfa_ctrl.sv =====
// Controller state machine of the frame allocator.
// Depends on bfa_pkg.
module bfa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  bfa_pkg::sts_t sts,
	output bfa_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done
);
	import bfa_pkg::*;

	state_t state_q, state_n;

	// Next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			S_CLEAR:    if (sts.clr_done) state_n = S_IDLE;
			S_IDLE:     if (start) state_n = S_DECODE;
			S_DECODE:   state_n = S_MARK_RD;
			S_MARK_RD: begin
				// state after decode, or after a found scan run: route by operation
				if (sts.op_fill)
					state_n = sts.fill_empty ? (sts.op_release ? S_FRAME0_RD : S_DONE)
						: S_FILL_WR;
				else if (sts.op_scan)
					state_n = S_SCAN_CHK;
				else if (sts.op_mark)
					state_n = S_MARK_WR;
				else
					state_n = S_DONE;
			end
			S_FILL_WR: begin
				if (sts.fill_last)
					state_n = sts.op_release ? S_FRAME0_RD : S_DONE;
				else
					state_n = S_FILL_RD;
			end
			S_FILL_RD:  state_n = S_FILL_WR;
			S_SCAN_CHK: begin
				if (sts.scan_found)
					state_n = S_SCAN_RD;
				else if (sts.scan_end)
					state_n = S_DONE;
				else if (sts.scan_word_end)
					state_n = S_SCAN_RD;
			end
			S_SCAN_RD: state_n = sts.scan_alloc ? S_MARK_RD : S_SCAN_CHK;
			S_MARK_WR:   state_n = S_DONE;
			S_FRAME0_RD: state_n = S_FRAME0_WR;
			S_FRAME0_WR: state_n = S_DONE;
			S_DONE:      state_n = S_IDLE;
			default:     state_n = S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd = '0;
		busy = (state_q != S_IDLE);
		done = 1'b0;
		case (state_q)
			S_CLEAR:     cmd.clr_step = 1'b1;
			S_IDLE:      cmd.load = start;
			S_DECODE:    cmd.decode = 1'b1;
			S_MARK_RD:   cmd.rd_cur = 1'b1;
			S_FILL_RD:   cmd.rd_cur = 1'b1;
			S_FILL_WR:   cmd.fill_wr = 1'b1;
			S_SCAN_RD:   cmd.rd_cur = 1'b1;
			S_SCAN_CHK:  cmd.scan_step = 1'b1;
			S_MARK_WR:   cmd.mark_wr = 1'b1;
			S_FRAME0_RD: cmd.f0_rd = 1'b1;
			S_FRAME0_WR: cmd.f0_wr = 1'b1;
			S_DONE: begin
				cmd.finish = 1'b1;
				done = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_CLEAR;
		else
			state_q <= state_n;
	end

endmodule

// ===== rtl/bitmap_frame_allocator_top.sv =====
// Top level of the bitmap frame allocator.
// Depends on bfa_pkg, bfa_ctrl, bfa_datapath.
//
// After reset the block sweeps the bitmap to all ones, one word a cycle,
// with busy high. An operation is taken when start is high and busy low;
// its one result beat appears with done high for one cycle and cannot be
// stalled. Region and free operations read, then write, each 32-frame
// bitmap word touched; a release then also sets frame 0. Allocation scans
// one frame per cycle, pausing to read each new word, up to the run's end,
// then fills the run with a read and a write per word; a mark reads, then
// writes, its word. The bitmap memory, one read and one write port, sets the pace.
module bitmap_frame_allocator_top #(
	parameter int FRAMES      = bfa_pkg::FRAMES_DEF,
	parameter int FRAME_BYTES = bfa_pkg::FRAME_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  bfa_pkg::req_t req,
	output logic          done,
	output bfa_pkg::rsp_t rsp,
	input  logic          cfg_we,
	input  logic [15:0]   cfg_data
);
	import bfa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bfa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .sts(sts),
		.cmd(cmd), .busy(busy), .done(done)
	);

	bfa_datapath #(.FRAMES(FRAMES), .FRAME_BYTES(FRAME_BYTES)) u_dp (
		.clk(clk), .arst_n(arst_n), .req(req), .cfg_we(cfg_we),
		.cfg_data(cfg_data), .cmd(cmd), .sts(sts), .rsp(rsp)
	);

endmodule

// ===== rtl/bfa_checker.sv =====
// Port-level checker for the frame allocator, bound to the top level.
// Depends on bfa_pkg.
module bfa_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input bfa_pkg::rsp_t rsp
);
	import bfa_pkg::*;

	// An accepted beat makes the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("not busy after accept");

	// Result beat is a single cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");

	// Done only while busy
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done while idle");

	// Failed allocation reports no address
	a_fail_addr: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != ST_OK |-> rsp.result_address == 32'd0)
		else $error("address on failure");

endmodule

bind bitmap_frame_allocator_top bfa_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.done(done), .rsp(rsp)
);
